@@ hw/rtl/mssclp_pkg.sv @@
// Shared types, constants and checksum helper for the TCP SYN MSS clamp
package mssclp_pkg;

  localparam logic [7:0] OPT_KIND_END  = 8'd0;
  localparam logic [7:0] OPT_KIND_PAD  = 8'd1;
  localparam logic [7:0] OPT_KIND_MSS  = 8'd2;
  localparam logic [7:0] OPT_LEN_MSS   = 8'd4;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [12:0] FRAG_OFF_MASK = 13'h1FFF;
  localparam logic [7:0] BYTE_MASK     = 8'hFF;

  typedef enum logic [1:0] {
    VERDICT_NOT_ELIGIBLE = 2'd0,
    VERDICT_NO_MSS       = 2'd1,
    VERDICT_WITHIN       = 2'd2,
    VERDICT_CLAMPED      = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    PH_KIND = 3'd0,
    PH_LEN  = 3'd1,
    PH_HI   = 3'd2,
    PH_LO   = 3'd3,
    PH_DONE = 3'd4
  } opt_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_ipv4_frame;
    logic       csum_seed;
  } in_word_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] mss_offset;
    logic [15:0] new_mss;
    logic        checksum_update;
    logic [15:0] new_checksum;
    logic [15:0] checksum_offset;
  } out_word_t;

  // incremental one's complement update of a 16-bit field
  function automatic logic [15:0] csum_adjust(input logic [15:0] hc,
                                              input logic [15:0] m_old,
                                              input logic [15:0] m_new);
    logic [17:0] s;
    logic [16:0] f1;
    logic [15:0] f2;
    s  = {2'b00, ~hc} + {2'b00, ~m_old} + {2'b00, m_new};
    f1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

endpackage

@@ hw/rtl/mssclp_parser.sv @@
// Per-byte IPv4/TCP header parser, option walker and verdict logic
module mssclp_parser import mssclp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_word_t    word_i,
  input  logic [15:0] max_mss_i,
  output out_word_t   result_o
);

  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic [5:0]  iph_q, iph_d;
  logic [15:0] tot_q, tot_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [5:0]  tcph_q, tcph_d;
  logic        syn_q, syn_d;
  logic [15:0] csum_q, csum_d;
  opt_phase_e  phase_q, phase_d;
  logic [5:0]  nstart_q, nstart_d;
  logic [7:0]  kind_q, kind_d;
  logic        found_q, found_d;
  logic [15:0] mss_q, mss_d;

  logic [7:0]  b;
  logic [15:0] pos;
  logic [15:0] iph_ext;
  logic [5:0]  optlen;
  logic [6:0]  opt_start;
  logic [15:0] rel;
  logic        in_opt;
  logic [5:0]  r;
  logic [8:0]  len_sum;
  logic [16:0] pkt_len;
  logic [16:0] hdrs_sum;
  logic        eligible;
  logic [7:0]  mss_off;

  assign b       = word_i.data_byte & BYTE_MASK;
  assign pos     = byte_cnt_q;
  assign iph_d   = (pos == 16'd0) ? {b[3:0], 2'b00} : iph_q;
  assign iph_ext = {10'd0, iph_d};

  always_comb begin
    hdr_ok_d = hdr_ok_q;
    tot_d    = tot_q;
    tcph_d   = tcph_q;
    syn_d    = syn_q;
    csum_d   = csum_q;

    if (pos == 16'd0) begin
      hdr_ok_d = word_i.is_ipv4_frame && (b[7:4] == 4'd4) && (b[3:0] >= 4'd5);
    end
    if (pos == 16'd2) tot_d[15:8] = b;
    if (pos == 16'd3) tot_d[7:0] = b;
    if (pos == 16'd6 && (b[4:0] & FRAG_OFF_MASK[12:8]) != 5'd0) hdr_ok_d = 1'b0;
    if (pos == 16'd7 && (b & FRAG_OFF_MASK[7:0]) != 8'd0) hdr_ok_d = 1'b0;
    if (pos == 16'd9 && b != PROTO_TCP) hdr_ok_d = 1'b0;
    if (pos == iph_ext + 16'd12) tcph_d = {b[7:4], 2'b00};
    if (pos == iph_ext + 16'd13) syn_d = b[1];
    if (pos == iph_ext + 16'd16) csum_d[15:8] = b;
    if (pos == iph_ext + 16'd17) csum_d[7:0] = b;
  end

  assign optlen    = (tcph_d >= 6'd20) ? (tcph_d - 6'd20) : 6'd0;
  assign opt_start = {1'b0, iph_d} + 7'd20;
  assign rel       = pos - {9'd0, opt_start};
  assign in_opt    = (pos >= {9'd0, opt_start}) && (rel < {10'd0, optlen});
  assign r         = rel[5:0];
  assign len_sum   = {3'd0, nstart_q} + {1'b0, b};

  // option walk, one byte of the option area per step
  always_comb begin
    phase_d  = phase_q;
    nstart_d = nstart_q;
    kind_d   = kind_q;
    found_d  = found_q;
    mss_d    = mss_q;
    if (in_opt) begin
      unique case (phase_q)
        PH_KIND: begin
          if (r == nstart_q) begin
            if (b == OPT_KIND_END) begin
              phase_d = PH_DONE;
            end else if (b == OPT_KIND_PAD) begin
              nstart_d = r + 6'd1;
            end else if ({1'b0, r} + 7'd1 >= {1'b0, optlen}) begin
              phase_d = PH_DONE;
            end else begin
              kind_d  = b;
              phase_d = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (b == 8'd0 || len_sum > {3'd0, optlen}) begin
            phase_d = PH_DONE;
          end else if (kind_q == OPT_KIND_MSS && b == OPT_LEN_MSS) begin
            phase_d = PH_HI;
          end else if (b == 8'd1) begin
            // length byte of one skips the kind and length bytes
            nstart_d = nstart_q + 6'd2;
            phase_d  = PH_KIND;
          end else begin
            nstart_d = len_sum[5:0];
            phase_d  = PH_KIND;
          end
        end
        PH_HI: begin
          mss_d   = {b, 8'd0};
          phase_d = PH_LO;
        end
        PH_LO: begin
          mss_d   = {mss_q[15:8], b};
          found_d = 1'b1;
          phase_d = PH_DONE;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign byte_cnt_d = (byte_cnt_q == 16'hFFFF) ? byte_cnt_q : byte_cnt_q + 16'd1;

  assign pkt_len  = {1'b0, pos} + 17'd1;
  assign hdrs_sum = {11'd0, tcph_d} + {11'd0, iph_d};
  assign eligible = hdr_ok_d && (tot_d >= {9'd0, opt_start}) && ({1'b0, tot_d} <= pkt_len)
                    && syn_d && (tcph_d >= 6'd20) && (hdrs_sum <= {1'b0, tot_d})
                    && (max_mss_i != 16'd0);
  assign mss_off  = {1'b0, opt_start} + {2'b00, nstart_d} + 8'd2;

  always_comb begin
    result_o = '0;
    result_o.verdict = VERDICT_NOT_ELIGIBLE;
    if (eligible) begin
      if (!found_d) begin
        result_o.verdict = VERDICT_NO_MSS;
      end else begin
        result_o.mss_offset = {8'd0, mss_off};
        if (mss_d <= max_mss_i) begin
          result_o.verdict = VERDICT_WITHIN;
        end else begin
          result_o.verdict         = VERDICT_CLAMPED;
          result_o.new_mss         = max_mss_i;
          result_o.checksum_offset = iph_ext + 16'd16;
          if (!word_i.csum_seed) begin
            result_o.checksum_update = 1'b1;
            result_o.new_checksum    = csum_adjust(csum_d, mss_d, max_mss_i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      iph_q      <= '0;
      tot_q      <= '0;
      hdr_ok_q   <= 1'b0;
      tcph_q     <= '0;
      syn_q      <= 1'b0;
      csum_q     <= '0;
      phase_q    <= PH_KIND;
      nstart_q   <= '0;
      kind_q     <= '0;
      found_q    <= 1'b0;
      mss_q      <= '0;
    end else if (step_i) begin
      if (word_i.last_byte) begin
        // packet done, start clean for the next one
        byte_cnt_q <= '0;
        iph_q      <= '0;
        tot_q      <= '0;
        hdr_ok_q   <= 1'b0;
        tcph_q     <= '0;
        syn_q      <= 1'b0;
        csum_q     <= '0;
        phase_q    <= PH_KIND;
        nstart_q   <= '0;
        kind_q     <= '0;
        found_q    <= 1'b0;
        mss_q      <= '0;
      end else begin
        byte_cnt_q <= byte_cnt_d;
        iph_q      <= iph_d;
        tot_q      <= tot_d;
        hdr_ok_q   <= hdr_ok_d;
        tcph_q     <= tcph_d;
        syn_q      <= syn_d;
        csum_q     <= csum_d;
        phase_q    <= phase_d;
        nstart_q   <= nstart_d;
        kind_q     <= kind_d;
        found_q    <= found_d;
        mss_q      <= mss_d;
      end
    end
  end

endmodule

@@ hw/rtl/tcp_syn_mss_clamp.sv @@
// TCP SYN MSS clamp top level: input register, parser and result register
// Takes an IPv4 packet one byte per word, one word per cycle unless stalled, and
// gives a single result word for the word flagged as the last byte. A word
// waits in the input register while the parser works on it. As the word
// moves on, the parser state advances and, for a last byte, the result
// lands in the output register. The input side only stalls when a last byte
// meets a result that is still held downstream. max_mss is for the user to
// write via cfg_we_i/cfg_wdata_i only while no packet is in flight; the block
// does not check this. Zero turns clamping off; every packet is not-eligible.
module tcp_syn_mss_clamp import mssclp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic        s1_valid_q;
  in_word_t    s1_word_q;
  logic        out_valid_q;
  out_word_t   out_word_q;
  logic [15:0] max_mss_q;
  logic        out_free;
  logic        s1_go;
  logic        in_take;
  out_word_t   result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_word_q.last_byte || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_mss_q <= '0;
    end else if (cfg_we_i) begin
      max_mss_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || s1_go) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_word_q <= in_word_i;
    end
  end

  mssclp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_go),
    .word_i    (s1_word_q),
    .max_mss_i (max_mss_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_word_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_word_q.last_byte) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a finished packet always produces a result word
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_word_q.last_byte |=> out_valid_q)
    else $error("last byte did not produce a result word");

  // a held result is never overwritten by the next packet
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && s1_valid_q && s1_word_q.last_byte |-> in_stall_o)
    else $error("result word overwritten while stalled");

  // checksum rewrite only comes with a clamp
  a_csum_needs_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.checksum_update |-> out_word_q.verdict == VERDICT_CLAMPED)
    else $error("checksum update without clamp verdict");

  // the input only stalls with a pending last byte and a held result word
  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_word_q.last_byte && out_valid_q)
    else $error("input stalled with no pending last byte");

endmodule
